FILE: hw/rtl/qbz_pkg.sv
// ----------------------------------------------------------------------------
// qbz_pkg: shared types, constants and functions
// Sizes, the curve record layout and the Bernstein weight table used by the
// quadratic Bezier point generator.
// ----------------------------------------------------------------------------
package qbz_pkg;

   // Number of segments per curve; each curve yields SEGMENTS+1 points.
   localparam int SEGMENTS = 10;
   localparam int STEP_W   = $clog2(SEGMENTS + 1);

   // Common denominator of the three weights and the width that holds it.
   localparam int DEN      = SEGMENTS * SEGMENTS;
   localparam int WGT_W    = $clog2(DEN + 1);

   // Coordinate and datapath widths.
   localparam int COORD_W  = 16;
   localparam int PROD_W   = COORD_W + WGT_W + 1;
   localparam int MAG_W    = COORD_W - 1 + WGT_W;
   localparam int EST_W    = 2 * MAG_W;

   // Reciprocal of DEN scaled by 2^MAG_W; the quotient estimate is at most
   // one below the true quotient for any numerator below 2^MAG_W.
   localparam longint RECIP = (longint'(1) << MAG_W) / DEN;

   // Curve queue between the front and back ends.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Register levels in the point evaluation pipeline, output included.
   localparam int PIPE_STAGES = 5;

   // Stream data widths.
   localparam int REQ_DATA_W = 6 * COORD_W;
   localparam int RSP_DATA_W = 2 * COORD_W;

   typedef logic signed [COORD_W-1:0] coord_type;

   // One curve; start_x sits in the lowest bits.
   typedef struct packed {
      coord_type end_y;
      coord_type end_x;
      coord_type ctrl_y;
      coord_type ctrl_x;
      coord_type start_y;
      coord_type start_x;
   } curve_type;

   // Bernstein weights of one step, scaled by DEN.
   typedef struct packed {
      logic [WGT_W-1:0] w_start;
      logic [WGT_W-1:0] w_ctrl;
      logic [WGT_W-1:0] w_end;
   } weights_type;

   // Head of the curve queue as seen by the back end.
   typedef struct packed {
      logic      valid;
      curve_type curve;
   } queue_link_type;

   // Weights for step i with u = SEGMENTS - i: u*u, 2*u*i and i*i.
   function automatic weights_type weights_for(input logic [STEP_W-1:0] step);
      logic [WGT_W-1:0] iw;
      logic [WGT_W-1:0] uw;
      weights_type      w;
      iw        = WGT_W'(step);
      uw        = WGT_W'(SEGMENTS) - iw;
      w.w_start = uw * uw;
      w.w_ctrl  = WGT_W'(2) * uw * iw;
      w.w_end   = iw * iw;
      return w;
   endfunction

endpackage

FILE: hw/rtl/quadratic_bezier_point_generator.sv
// ----------------------------------------------------------------------------
// quadratic_bezier_point_generator: quadratic Bezier curve point stream
// Each request word is one curve; the block answers with SEGMENTS+1 points
// along it, start point first and the end point marked by tlast.
// ----------------------------------------------------------------------------
// Each accepted curve produces 11 response words (SEGMENTS+1), one per cycle
// while the response side is ready; the single point evaluation pipeline
// handles one step of one curve per cycle. The first point of a curve is
// registered in turn in the product, magnitude, estimate, back-multiply and
// result levels once the curve is at the head of the intake queue. The queue
// holds two curves, so a new curve is taken while the previous one is still
// being emitted. Coordinates are exact: (s*u*u + 2*c*u*i + e*i*i)/SEGMENTS^2
// with u = SEGMENTS - i, truncated toward zero.
module quadratic_bezier_point_generator (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // start_x, start_y, ctrl_x, ctrl_y, end_x, end_y (16 bits each, signed)
   input  logic [qbz_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // point_x, point_y (16 bits each, signed)
   output logic [qbz_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                               rsp_tlast
);

   qbz_pkg::queue_link_type head;
   logic                    pop;

   // Intake queue.
   qbz_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .pop        (pop),
      .head       (head)
   );

   // Point sequencer and evaluation pipeline.
   qbz_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // A curve leaves the queue only while one is present.
   a_pop_needs_head: assert property (@(posedge clock) disable iff (reset)
      pop |-> head.valid)
      else $error("curve queue popped while empty");

   // The queue can run empty only through a pop.
   a_empty_after_pop: assert property (@(posedge clock) disable iff (reset)
      $fell(head.valid) |-> $past(pop))
      else $error("curve queue head lost without a pop");

   // A full queue always presents a curve to the back end.
   a_full_has_head: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> head.valid)
      else $error("queue refuses requests while holding no curve");

endmodule

FILE: hw/rtl/qbz_front.sv
// ----------------------------------------------------------------------------
// qbz_front: curve intake queue
// Accepts curve words from the request stream and holds them in a short
// queue until the back end has issued the last step of the curve at its head.
// ----------------------------------------------------------------------------
module qbz_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [qbz_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic                               pop,
   output qbz_pkg::queue_link_type            head
);

   qbz_pkg::curve_type              entry_ff [qbz_pkg::QUEUE_DEPTH];
   logic [qbz_pkg::QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [qbz_pkg::QPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [qbz_pkg::QCNT_W-1:0]      count_ff, count_in;
   logic                            push;

   // Room is left as long as the queue is not full.
   assign req_tready = (count_ff != qbz_pkg::QCNT_W'(qbz_pkg::QUEUE_DEPTH));
   assign push       = req_tvalid && req_tready;

   // The head entry is what the back end works on.
   assign head.valid = (count_ff != '0);
   assign head.curve = entry_ff[rd_ptr_ff];

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == qbz_pkg::QPTR_W'(qbz_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == qbz_pkg::QPTR_W'(qbz_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage; the request word unpacks straight into a curve record.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= qbz_pkg::curve_type'(req_tdata);
      end
   end

endmodule

FILE: hw/rtl/qbz_coord.sv
// ----------------------------------------------------------------------------
// qbz_coord: one coordinate of a curve point
// Five-level pipeline: weighted products, sum and magnitude, reciprocal
// multiply, quotient back-multiply, and correction with sign restore. It
// divides by SEGMENTS^2 with truncation toward zero.
// ----------------------------------------------------------------------------
module qbz_coord (
   input  logic                     clock,
   input  logic                     advance,
   input  qbz_pkg::coord_type       s_coord,
   input  qbz_pkg::coord_type       c_coord,
   input  qbz_pkg::coord_type       e_coord,
   input  qbz_pkg::weights_type     weights,
   output qbz_pkg::coord_type       point
);

   // Level A: the three weighted products.
   logic signed [qbz_pkg::PROD_W-1:0] prod_s_ff, prod_s_in;
   logic signed [qbz_pkg::PROD_W-1:0] prod_c_ff, prod_c_in;
   logic signed [qbz_pkg::PROD_W-1:0] prod_e_ff, prod_e_in;
   // Level B: magnitude and sign of the numerator.
   logic signed [qbz_pkg::PROD_W-1:0] sum;
   logic [qbz_pkg::PROD_W-1:0]        abs_val;
   logic [qbz_pkg::MAG_W-1:0]         mag_b_ff, mag_b_in;
   logic                              neg_b_ff, neg_b_in;
   // Level C: quotient estimate.
   logic [qbz_pkg::EST_W-1:0]         recip_prod;
   logic [qbz_pkg::COORD_W-1:0]       q_est_c_ff, q_est_c_in;
   logic [qbz_pkg::MAG_W-1:0]         mag_c_ff;
   logic                              neg_c_ff;
   // Level D: estimate times the denominator.
   logic [qbz_pkg::MAG_W-1:0]         qd_d_ff, qd_d_in;
   logic [qbz_pkg::COORD_W-1:0]       q_est_d_ff;
   logic [qbz_pkg::MAG_W-1:0]         mag_d_ff;
   logic                              neg_d_ff;
   // Level E: corrected, signed result.
   logic [qbz_pkg::MAG_W-1:0]         rem;
   logic [qbz_pkg::COORD_W-1:0]       q_fix;
   qbz_pkg::coord_type                point_ff, point_in;

   // Products of each coordinate with its unsigned weight.
   always_comb begin
      prod_s_in = qbz_pkg::PROD_W'(s_coord) *
                  qbz_pkg::PROD_W'($signed({1'b0, weights.w_start}));
      prod_c_in = qbz_pkg::PROD_W'(c_coord) *
                  qbz_pkg::PROD_W'($signed({1'b0, weights.w_ctrl}));
      prod_e_in = qbz_pkg::PROD_W'(e_coord) *
                  qbz_pkg::PROD_W'($signed({1'b0, weights.w_end}));
   end

   // The sum is a convex combination scaled by DEN, so it never overflows.
   always_comb begin
      sum      = prod_s_ff + prod_c_ff + prod_e_ff;
      neg_b_in = sum[qbz_pkg::PROD_W-1];
      abs_val  = neg_b_in ? qbz_pkg::PROD_W'(-sum) : qbz_pkg::PROD_W'(sum);
      mag_b_in = abs_val[qbz_pkg::MAG_W-1:0];
   end

   // Multiply by the scaled reciprocal; the estimate is low by at most one.
   always_comb begin
      recip_prod = qbz_pkg::EST_W'(mag_b_ff) * qbz_pkg::EST_W'(qbz_pkg::RECIP);
      q_est_c_in = recip_prod[qbz_pkg::MAG_W +: qbz_pkg::COORD_W];
   end

   assign qd_d_in = qbz_pkg::MAG_W'(qbz_pkg::MAG_W'(q_est_c_ff) *
                                    qbz_pkg::MAG_W'(qbz_pkg::DEN));

   // One compare corrects the estimate; then the sign goes back on.
   always_comb begin
      rem      = mag_d_ff - qd_d_ff;
      q_fix    = q_est_d_ff + qbz_pkg::COORD_W'(rem >= qbz_pkg::MAG_W'(qbz_pkg::DEN));
      point_in = neg_d_ff ? $signed(-q_fix) : $signed(q_fix);
   end

   // All levels move together when the pipeline advances.
   always_ff @(posedge clock) begin
      if (advance) begin
         prod_s_ff  <= prod_s_in;
         prod_c_ff  <= prod_c_in;
         prod_e_ff  <= prod_e_in;
         mag_b_ff   <= mag_b_in;
         neg_b_ff   <= neg_b_in;
         q_est_c_ff <= q_est_c_in;
         mag_c_ff   <= mag_b_ff;
         neg_c_ff   <= neg_b_ff;
         qd_d_ff    <= qd_d_in;
         q_est_d_ff <= q_est_c_ff;
         mag_d_ff   <= mag_c_ff;
         neg_d_ff   <= neg_c_ff;
         point_ff   <= point_in;
      end
   end

   assign point = point_ff;

endmodule

FILE: hw/rtl/qbz_back.sv
// ----------------------------------------------------------------------------
// qbz_back: point sequencer and evaluation pipeline
// Steps through the head curve, one step per cycle while the pipeline moves,
// and feeds the x and y pipelines; their last level is the response register.
// ----------------------------------------------------------------------------
module qbz_back (
   input  logic                               clock,
   input  logic                               reset,
   input  qbz_pkg::queue_link_type            head,
   output logic                               pop,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [qbz_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                               rsp_tlast
);

   logic [qbz_pkg::STEP_W-1:0]     step_ff, step_in;
   logic [qbz_pkg::PIPE_STAGES-1:0] valid_ff, valid_in;
   logic [qbz_pkg::PIPE_STAGES-1:0] last_ff, last_in;
   logic                           advance;
   logic                           issue;
   logic                           step_last;
   qbz_pkg::weights_type           weights;
   qbz_pkg::coord_type             point_x;
   qbz_pkg::coord_type             point_y;

   // The whole pipeline moves unless a finished point waits at the output.
   assign advance   = !valid_ff[qbz_pkg::PIPE_STAGES-1] || rsp_tready;
   assign issue     = advance && head.valid;
   assign step_last = (step_ff == qbz_pkg::STEP_W'(qbz_pkg::SEGMENTS));
   assign pop       = issue && step_last;
   assign weights   = qbz_pkg::weights_for(step_ff);

   // Step counter wraps after the end point of each curve.
   always_comb begin
      step_in = step_ff;
      if (issue) begin
         step_in = step_last ? '0 : step_ff + 1'b1;
      end
   end

   // Valid and last flags travel alongside the coordinate pipelines.
   always_comb begin
      valid_in = {valid_ff[qbz_pkg::PIPE_STAGES-2:0], issue};
      last_in  = {last_ff[qbz_pkg::PIPE_STAGES-2:0], step_last};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= '0;
         valid_ff <= '0;
      end else begin
         step_ff <= step_in;
         if (advance) begin
            valid_ff <= valid_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         last_ff <= last_in;
      end
   end

   // X coordinate pipeline.
   qbz_coord u_coord_x (
      .clock   (clock),
      .advance (advance),
      .s_coord (head.curve.start_x),
      .c_coord (head.curve.ctrl_x),
      .e_coord (head.curve.end_x),
      .weights (weights),
      .point   (point_x)
   );

   // Y coordinate pipeline.
   qbz_coord u_coord_y (
      .clock   (clock),
      .advance (advance),
      .s_coord (head.curve.start_y),
      .c_coord (head.curve.ctrl_y),
      .e_coord (head.curve.end_y),
      .weights (weights),
      .point   (point_y)
   );

   assign rsp_tvalid = valid_ff[qbz_pkg::PIPE_STAGES-1];
   assign rsp_tlast  = last_ff[qbz_pkg::PIPE_STAGES-1];
   assign rsp_tdata  = {point_y, point_x};

endmodule

FILE: sim/quadratic_bezier_point_generator_tb.sv
// ----------------------------------------------------------------------------
// quadratic_bezier_point_generator_tb: self-checking bench for the Bezier block
// Drives curve words into the block and checks every point word that comes
// back. For each accepted curve, the bench computes the SEGMENTS+1 points
// in exact integer form. It then compares them in order with the response
// stream. Both sides idle at random except in one stretch at full rate.
// ----------------------------------------------------------------------------
module quadratic_bezier_point_generator_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int                 CYCLE_LIMIT  = 600000;
   localparam int                 DRAIN_CYCLES = 40;
   localparam qbz_pkg::coord_type COORD_MAX    = 16'sh7FFF;
   localparam qbz_pkg::coord_type COORD_MIN    = 16'sh8000;

   // One expected point on the response stream.
   typedef struct {
      qbz_pkg::coord_type x;
      qbz_pkg::coord_type y;
      logic               last;
   } point_type;

   logic                           clock = 1'b0;
   logic                           reset;
   logic                           req_tvalid;
   logic                           req_tready;
   // start_x, start_y, ctrl_x, ctrl_y, end_x, end_y (16 bits each, signed)
   logic [qbz_pkg::REQ_DATA_W-1:0] req_tdata;
   logic                           rsp_tvalid;
   logic                           rsp_tready;
   // point_x, point_y (16 bits each, signed)
   logic [qbz_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                           rsp_tlast;

   int   cycle_count = 0;
   bit   sender_gaps   = 1'b1;
   bit   receiver_stalls = 1'b1;

   // Exact Bezier coordinate for one step, truncated toward zero.
   function automatic qbz_pkg::coord_type bezier_coord(qbz_pkg::coord_type s,
                                                       qbz_pkg::coord_type c,
                                                       qbz_pkg::coord_type e,
                                                       int step);
      longint u;
      longint i;
      longint num;
      u   = longint'(qbz_pkg::SEGMENTS - step);
      i   = longint'(step);
      num = longint'(s) * u * u + 2 * longint'(c) * u * i + longint'(e) * i * i;
      return qbz_pkg::coord_type'(num / longint'(qbz_pkg::SEGMENTS * qbz_pkg::SEGMENTS));
   endfunction

   // Holds the points still owed by the block and checks arriving words.
   class point_scoreboard;
      point_type expected_points[$];
      int        errors = 0;

      function void report(string msg);
         $display("%s", msg);
         errors++;
      endfunction

      function void note_curve(qbz_pkg::curve_type c);
         point_type p;
         for (int k = 0; k <= qbz_pkg::SEGMENTS; k++) begin
            p.x    = bezier_coord(c.start_x, c.ctrl_x, c.end_x, k);
            p.y    = bezier_coord(c.start_y, c.ctrl_y, c.end_y, k);
            p.last = (k == qbz_pkg::SEGMENTS);
            expected_points.insert(expected_points.size(), p);
         end
      endfunction

      function void check_point(logic [qbz_pkg::RSP_DATA_W-1:0] word, logic last);
         point_type          want;
         qbz_pkg::coord_type got_x;
         qbz_pkg::coord_type got_y;
         got_x = word[qbz_pkg::COORD_W-1:0];
         got_y = word[2*qbz_pkg::COORD_W-1:qbz_pkg::COORD_W];
         if (expected_points.size() == 0) begin
            report($sformatf("%0t: unexpected point word x=%0d y=%0d last=%0b",
                             $time, got_x, got_y, last));
            return;
         end
         want = expected_points.pop_front();
         if (got_x !== want.x)
            report($sformatf("%0t: point_x expected %0d got %0d", $time, want.x, got_x));
         if (got_y !== want.y)
            report($sformatf("%0t: point_y expected %0d got %0d", $time, want.y, got_y));
         if (last !== want.last)
            report($sformatf("%0t: last_point expected %0b got %0b",
                             $time, want.last, last));
      endfunction

      function int pending();
         return expected_points.size();
      endfunction
   endclass

   point_scoreboard points_board = new();

   quadratic_bezier_point_generator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // 12 ns clock.
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Idle length: mostly none or short, now and then long.
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(6, 40);
   endfunction

   // Coordinate mix: extremes, small values near zero, and full-range noise.
   function automatic qbz_pkg::coord_type pick_coord();
      int r;
      r = $urandom_range(0, 99);
      if (r < 15) begin
         case ($urandom_range(0, 4))
            0:       return COORD_MAX;
            1:       return COORD_MIN;
            2:       return qbz_pkg::coord_type'(0);
            3:       return qbz_pkg::coord_type'(-1);
            default: return qbz_pkg::coord_type'(1);
         endcase
      end
      if (r < 30) return qbz_pkg::coord_type'(int'($urandom_range(0, 40)) - 20);
      return qbz_pkg::coord_type'($urandom);
   endfunction

   function automatic qbz_pkg::curve_type make_curve(int sx, int sy, int cx, int cy,
                                                     int ex, int ey);
      qbz_pkg::curve_type c;
      c.start_x = qbz_pkg::coord_type'(sx);
      c.start_y = qbz_pkg::coord_type'(sy);
      c.ctrl_x  = qbz_pkg::coord_type'(cx);
      c.ctrl_y  = qbz_pkg::coord_type'(cy);
      c.end_x   = qbz_pkg::coord_type'(ex);
      c.end_y   = qbz_pkg::coord_type'(ey);
      return c;
   endfunction

   // Send one curve word. Entered and left at a falling edge; valid stays
   // high on exit so back-to-back words need no extra transition.
   task automatic send_curve(qbz_pkg::curve_type c);
      int gap;
      gap = sender_gaps ? idle_len() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      do @(posedge clock); while (!req_tready);
      points_board.note_curve(c);
      @(negedge clock);
   endtask

   task automatic send_random_curves(int count);
      qbz_pkg::curve_type c;
      for (int n = 0; n < count; n++) begin
         c.start_x = pick_coord();
         c.start_y = pick_coord();
         c.ctrl_x  = pick_coord();
         c.ctrl_y  = pick_coord();
         c.end_x   = pick_coord();
         c.end_y   = pick_coord();
         send_curve(c);
      end
   endtask

   // Response side: ready at the falling edge, with random stalls.
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else if (receiver_stalls && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            stall_left = idle_len();
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Check each point word accepted at the rising edge.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         points_board.check_point(rsp_tdata, rsp_tlast);
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("quadratic_bezier_point_generator_tb: FAIL");
         $finish;
      end
   end

   // Main sequence.
   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed curves: extremes, truncation toward zero, degenerate shapes.
      send_curve(make_curve(0, 0, 0, 0, 0, 0));
      send_curve(make_curve(32767, 32767, 32767, 32767, 32767, 32767));
      send_curve(make_curve(-32768, -32768, -32768, -32768, -32768, -32768));
      send_curve(make_curve(-32768, 32767, 32767, -32768, -32768, 32767));
      send_curve(make_curve(32767, -32768, -32768, 32767, 32767, -32768));
      send_curve(make_curve(32767, -32768, 0, 0, -32768, 32767));
      send_curve(make_curve(-32768, 32767, 0, 0, 32767, -32768));
      // Small negative sums must round toward zero, not down.
      send_curve(make_curve(-1, 0, -1, -1, 0, -1));
      send_curve(make_curve(1, -1, 0, 1, -1, 0));
      send_curve(make_curve(-7, 7, 3, -3, -13, 13));
      // Straight line: the control point sits on the chord.
      send_curve(make_curve(-1000, 200, 0, 700, 1000, 1200));
      // Alternating bit patterns across every field.
      send_curve(make_curve(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA));
      send_curve(make_curve(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555));
      send_curve(make_curve(0, 0, 32767, -32768, 0, 0));

      // Random curves with idling on both sides.
      send_random_curves(70);

      // Let the block drain completely before going on.
      req_tvalid <= 1'b0;
      while (points_board.pending() != 0) @(negedge clock);

      // A stretch at full rate with no idling.
      sender_gaps     = 1'b0;
      receiver_stalls = 1'b0;
      send_random_curves(70);

      sender_gaps     = 1'b1;
      receiver_stalls = 1'b1;
      send_random_curves(75);
      req_tvalid <= 1'b0;

      while (points_board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (points_board.errors == 0)
         $display("quadratic_bezier_point_generator_tb: PASS");
      else
         $display("quadratic_bezier_point_generator_tb: FAIL");
      $finish;
   end

endmodule
